### hw/rtl/jddm_pkg.sv
// Joystick differential drive mixer: shared types and constants.
// Used by jddm_axis_scale, jddm_mix and joystick_differential_drive_mixer.
package jddm_pkg;

    localparam logic [9:0]  AXIS_CENTER = 10'd510;
    localparam logic [7:0]  DUTY_MAX    = 8'd255;

    localparam logic [9:0]  UPPER_RESET = 10'd550;
    localparam logic [8:0]  LOWER_RESET = 9'd470;

    // floor(n / d) ~ (n * RECIP) >> RECIP_SHIFT, off by at most one low
    localparam int          RECIP_SHIFT = 26;
    localparam logic [17:0] RECIP_POS   = 18'd130816;   // floor(2^26 / 513)
    localparam logic [17:0] RECIP_NEG   = 18'd131585;   // floor(2^26 / 510) - 1
    localparam logic [16:0] DIV_POS     = 17'd513;
    localparam logic [16:0] DIV_NEG     = 17'd510;

    localparam logic [0:0]  REG_UPPER   = 1'b0;
    localparam logic [0:0]  REG_LOWER   = 1'b1;

    typedef enum logic [2:0] {
        DIR_FORWARD  = 3'd0,
        DIR_BACKWARD = 3'd1,
        DIR_RIGHT    = 3'd2,
        DIR_LEFT     = 3'd3,
        DIR_NEUTRAL  = 3'd4
    } dir_t;

    typedef struct packed {
        logic vld;
        dir_t dir;
        logic spd_on;     // Y magnitude is on the drive side of center
        logic steer_pos;  // X right of center and above upper threshold
        logic steer_neg;  // X left of center and below lower threshold
        logic turn_on;    // spin turn with X on the turn side of center
    } mix_ctrl_t;

endpackage

### hw/rtl/jddm_axis_scale.sv
// One axis: |v - 510| * 255 / (513 above center, 510 below), truncated.
// Three register stages: deflection, reciprocal multiply, correction.
// Depends on jddm_pkg.
module jddm_axis_scale
    import jddm_pkg::*;
(
    input  logic       clk,
    input  logic [9:0] sample,
    output logic [7:0] mag
);

    logic        above;
    logic [9:0]  defl;
    logic [17:0] defl_wide;
    logic [16:0] n_next;
    logic [16:0] n_reg;
    logic        neg_reg;

    logic [17:0] recip;
    logic [34:0] prod;
    logic [7:0]  q0_next;
    logic [7:0]  q0_reg;
    logic [16:0] n2_reg;
    logic        neg2_reg;

    logic [16:0] qd;
    logic [16:0] rem;
    logic [16:0] div;
    logic [7:0]  mag_next;
    logic [7:0]  mag_reg;

    always_comb
    begin
        above     = sample > AXIS_CENTER;
        defl      = above ? sample - AXIS_CENTER : AXIS_CENTER - sample;
        defl_wide = {8'b0, defl};
        n_next    = 17'((defl_wide << 8) - defl_wide);
    end

    always_comb
    begin
        recip   = neg_reg ? RECIP_NEG : RECIP_POS;
        prod    = {18'b0, n_reg} * {17'b0, recip};
        q0_next = prod[RECIP_SHIFT +: 8];
    end

    always_comb
    begin
        if (neg2_reg)
        begin
            qd  = ({9'b0, q0_reg} << 9) - ({9'b0, q0_reg} << 1);
            div = DIV_NEG;
        end
        else
        begin
            qd  = ({9'b0, q0_reg} << 9) + {9'b0, q0_reg};
            div = DIV_POS;
        end
        rem      = n2_reg - qd;
        mag_next = (rem >= div) ? q0_reg + 8'd1 : q0_reg;
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        neg_reg  <= ~above;
        q0_reg   <= q0_next;
        n2_reg   <= n_reg;
        neg2_reg <= neg_reg;
        mag_reg  <= mag_next;
    end

    assign mag = mag_reg;

endmodule

### hw/rtl/jddm_mix.sv
// Final stage: steering mix with saturation, H-bridge decode, result register.
// Depends on jddm_pkg.
module jddm_mix
    import jddm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  mix_ctrl_t  ctrl,
    input  logic [7:0] mag_x,
    input  logic [7:0] mag_y,
    output logic       done,
    output logic [2:0] direction,
    output logic [3:0] bridge_bits,
    output logic [7:0] right_duty,
    output logic [7:0] left_duty
);

    logic [7:0] base;
    logic [8:0] sum_r;
    logic [8:0] sum_l;
    logic [7:0] right_next;
    logic [7:0] left_next;
    logic [3:0] bits_next;

    logic       done_reg;
    logic [2:0] dir_reg;
    logic [3:0] bits_reg;
    logic [7:0] right_reg;
    logic [7:0] left_reg;

    always_comb
    begin
        base       = ctrl.spd_on ? mag_y : 8'd0;
        sum_r      = {1'b0, base} + {1'b0, mag_x};
        sum_l      = sum_r;
        right_next = 8'd0;
        left_next  = 8'd0;
        bits_next  = 4'b0000;
        unique case (ctrl.dir) inside
            DIR_FORWARD, DIR_BACKWARD:
            begin
                right_next = base;
                left_next  = base;
                if (ctrl.steer_pos)
                begin
                    right_next = (base > mag_x) ? base - mag_x : 8'd0;
                    left_next  = sum_l[8] ? DUTY_MAX : sum_l[7:0];
                end
                else if (ctrl.steer_neg)
                begin
                    right_next = sum_r[8] ? DUTY_MAX : sum_r[7:0];
                    left_next  = (base > mag_x) ? base - mag_x : 8'd0;
                end
                bits_next = (ctrl.dir == DIR_FORWARD) ? 4'b0101 : 4'b1010;
            end
            DIR_RIGHT:
            begin
                right_next = ctrl.turn_on ? mag_x : 8'd0;
                left_next  = right_next;
                bits_next  = 4'b1001;
            end
            DIR_LEFT:
            begin
                right_next = ctrl.turn_on ? mag_x : 8'd0;
                left_next  = right_next;
                bits_next  = 4'b0110;
            end
            default:
            begin
                right_next = 8'd0;
                left_next  = 8'd0;
                bits_next  = 4'b0000;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        dir_reg   <= ctrl.dir;
        bits_reg  <= bits_next;
        right_reg <= right_next;
        left_reg  <= left_next;
    end

    assign done        = done_reg;
    assign direction   = dir_reg;
    assign bridge_bits = bits_reg;
    assign right_duty  = right_reg;
    assign left_duty   = left_reg;

endmodule

### hw/rtl/joystick_differential_drive_mixer.sv
// Joystick differential drive mixer, top level: input register, thresholds,
// direction decision and control pipeline. Depends on jddm_pkg, jddm_axis_scale, jddm_mix.
//
//  channel   signals                                          handshake
//  --------  -----------------------------------------------  ----------------------
//  item in   joystick_x, joystick_y, link_valid               start & !busy
//  item out  direction, bridge_bits, right_duty, left_duty    done, one cycle
//  config    cfg_index, cfg_data                              cfg_write
//
// One item per cycle; results appear in order.
// busy is always low: the five-stage pipeline has no loop and no shared unit.
// Latency is set by the reciprocal multiply and its correction step per axis.
// Reset clears the pipeline valid bits and loads thresholds 550 and 470.
// The receiver cannot stall; done marks each result for exactly one cycle.
module joystick_differential_drive_mixer
    import jddm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [9:0] joystick_x,
    input  logic [9:0] joystick_y,
    input  logic       link_valid,
    input  logic       cfg_write,
    input  logic [0:0] cfg_index,
    input  logic [9:0] cfg_data,
    output logic       done,
    output logic [2:0] direction,
    output logic [3:0] bridge_bits,
    output logic [7:0] right_duty,
    output logic [7:0] left_duty
);

    logic [9:0] upper_reg;
    logic [8:0] lower_reg;

    logic       vld_reg;
    logic [9:0] x_reg;
    logic [9:0] y_reg;
    logic       link_reg;

    logic       xpos;
    logic       xneg;
    logic       ypos;
    logic       yneg;
    mix_ctrl_t  ctrl_next;
    mix_ctrl_t  ctrl1_reg;
    mix_ctrl_t  ctrl2_reg;
    mix_ctrl_t  ctrl3_reg;

    logic [7:0] mag_x;
    logic [7:0] mag_y;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg <= UPPER_RESET;
            lower_reg <= LOWER_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_UPPER: upper_reg <= cfg_data;
                REG_LOWER: lower_reg <= cfg_data[8:0];
                default:   upper_reg <= upper_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= joystick_x;
        y_reg    <= joystick_y;
        link_reg <= link_valid;
    end

    always_comb
    begin
        xpos = x_reg > upper_reg;
        xneg = x_reg < {1'b0, lower_reg};
        ypos = y_reg > upper_reg;
        yneg = y_reg < {1'b0, lower_reg};

        ctrl_next     = '0;
        ctrl_next.vld = vld_reg;
        if (!link_reg)
            ctrl_next.dir = DIR_NEUTRAL;
        else if (ypos)
            ctrl_next.dir = DIR_FORWARD;
        else if (yneg)
            ctrl_next.dir = DIR_BACKWARD;
        else if (xpos)
            ctrl_next.dir = DIR_RIGHT;
        else if (xneg)
            ctrl_next.dir = DIR_LEFT;
        else
            ctrl_next.dir = DIR_NEUTRAL;

        ctrl_next.spd_on    = (ctrl_next.dir == DIR_FORWARD && y_reg > AXIS_CENTER)
                           || (ctrl_next.dir == DIR_BACKWARD && y_reg < AXIS_CENTER);
        ctrl_next.steer_pos = xpos && x_reg > AXIS_CENTER;
        ctrl_next.steer_neg = xneg && x_reg < AXIS_CENTER;
        ctrl_next.turn_on   = (ctrl_next.dir == DIR_RIGHT && x_reg > AXIS_CENTER)
                           || (ctrl_next.dir == DIR_LEFT && x_reg < AXIS_CENTER);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl1_reg <= '0;
            ctrl2_reg <= '0;
            ctrl3_reg <= '0;
        end
        else
        begin
            ctrl1_reg <= ctrl_next;
            ctrl2_reg <= ctrl1_reg;
            ctrl3_reg <= ctrl2_reg;
        end
    end

    jddm_axis_scale u_scale_x
    (
        .clk    (clk),
        .sample (x_reg),
        .mag    (mag_x)
    );

    jddm_axis_scale u_scale_y
    (
        .clk    (clk),
        .sample (y_reg),
        .mag    (mag_y)
    );

    jddm_mix u_mix
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl3_reg),
        .mag_x       (mag_x),
        .mag_y       (mag_y),
        .done        (done),
        .direction   (direction),
        .bridge_bits (bridge_bits),
        .right_duty  (right_duty),
        .left_duty   (left_duty)
    );

    a_done_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 5))
        else $error("result without an accepted item");

    a_no_link_neutral: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(link_valid, 5) || direction == DIR_NEUTRAL))
        else $error("invalid link did not give neutral");

    a_neutral_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        (done && direction == DIR_NEUTRAL) |->
            (bridge_bits == 4'b0000 && right_duty == 8'd0 && left_duty == 8'd0))
        else $error("neutral result with drive");

    a_forward_needs_y: assert property (@(posedge clk) disable iff (!rst_n)
        (done && direction == DIR_FORWARD) |-> ($past(joystick_y, 5) > upper_reg))
        else $error("forward without Y above threshold");

endmodule

### tb/joystick_differential_drive_mixer_tb.sv
// Self-checking testbench for joystick_differential_drive_mixer: directed and random
// stick samples across several threshold settings, checked against an in-bench mixer model.
// Depends on jddm_pkg and the joystick_differential_drive_mixer RTL.
module joystick_differential_drive_mixer_tb
    import jddm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [9:0] x;
        logic [9:0] y;
        logic       v;
        dir_t       dir;
        logic [3:0] bits;
        logic [7:0] right;
        logic [7:0] left;
    } mix_result_t;

    class mix_scoreboard;
        mix_result_t pending_mixes[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endtask

        function void note_sample(mix_result_t exp_mix);
            pending_mixes.push_back(exp_mix);
        endfunction

        function int pending();
            return pending_mixes.size();
        endfunction

        task check_result(mix_result_t got);
            mix_result_t exp_mix;
            string       tag;
            if (pending_mixes.size() == 0)
            begin
                report($sformatf("unexpected result dir=%0d bits=%h r=%0d l=%0d",
                                 got.dir, got.bits, got.right, got.left));
                return;
            end
            exp_mix = pending_mixes.pop_front();
            tag = $sformatf("x=%0d y=%0d v=%0b", exp_mix.x, exp_mix.y, exp_mix.v);
            if (got.dir !== exp_mix.dir)
                report($sformatf("direction %0d, want %0d (%s)", got.dir, exp_mix.dir, tag));
            if (got.bits !== exp_mix.bits)
                report($sformatf("bridge_bits %h, want %h (%s)", got.bits, exp_mix.bits, tag));
            if (got.right !== exp_mix.right)
                report($sformatf("right_duty %0d, want %0d (%s)", got.right, exp_mix.right, tag));
            if (got.left !== exp_mix.left)
                report($sformatf("left_duty %0d, want %0d (%s)", got.left, exp_mix.left, tag));
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [9:0] joystick_x;
    logic [9:0] joystick_y;
    logic       link_valid;
    logic       cfg_write;
    logic [0:0] cfg_index;
    logic [9:0] cfg_data;
    logic       done;
    logic [2:0] direction;
    logic [3:0] bridge_bits;
    logic [7:0] right_duty;
    logic [7:0] left_duty;

    logic [9:0]    upper_thr;
    logic [8:0]    lower_thr;
    bit            burst_mode;
    mix_scoreboard sb;

    joystick_differential_drive_mixer u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .joystick_x  (joystick_x),
        .joystick_y  (joystick_y),
        .link_valid  (link_valid),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .direction   (direction),
        .bridge_bits (bridge_bits),
        .right_duty  (right_duty),
        .left_duty   (left_duty)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int scale_up(int v);
        if (v <= int'(AXIS_CENTER))
            return 0;
        return ((v - int'(AXIS_CENTER)) * int'(DUTY_MAX)) / int'(DIV_POS);
    endfunction

    function automatic int scale_down(int v);
        if (v >= int'(AXIS_CENTER))
            return 0;
        return ((int'(AXIS_CENTER) - v) * int'(DUTY_MAX)) / int'(DIV_NEG);
    endfunction

    function automatic mix_result_t predict_mix(logic [9:0] x, logic [9:0] y, logic v);
        mix_result_t m;
        int  xi;
        int  yi;
        int  r;
        int  l;
        int  xm;
        bit  xpos;
        bit  xneg;
        xi = int'(x);
        yi = int'(y);
        xpos = xi > int'(upper_thr);
        xneg = xi < int'(lower_thr);
        r = 0;
        l = 0;
        m.x = x;
        m.y = y;
        m.v = v;
        m.dir = DIR_NEUTRAL;
        if (v)
        begin
            if (yi > int'(upper_thr))
                m.dir = DIR_FORWARD;
            else if (yi < int'(lower_thr))
                m.dir = DIR_BACKWARD;
            else if (xpos)
                m.dir = DIR_RIGHT;
            else if (xneg)
                m.dir = DIR_LEFT;
        end
        case (m.dir) inside
            DIR_FORWARD, DIR_BACKWARD:
            begin
                r = (m.dir == DIR_FORWARD) ? scale_up(yi) : scale_down(yi);
                l = r;
                if (xpos)
                begin
                    xm = scale_up(xi);
                    r = (r > xm) ? r - xm : 0;
                    l = (l + xm > int'(DUTY_MAX)) ? int'(DUTY_MAX) : l + xm;
                end
                if (xneg)
                begin
                    xm = scale_down(xi);
                    r = (r + xm > int'(DUTY_MAX)) ? int'(DUTY_MAX) : r + xm;
                    l = (l > xm) ? l - xm : 0;
                end
            end
            DIR_RIGHT:
            begin
                r = scale_up(xi);
                l = r;
            end
            DIR_LEFT:
            begin
                r = scale_down(xi);
                l = r;
            end
            default:
            begin
                r = 0;
                l = 0;
            end
        endcase
        m.bits[0] = (m.dir == DIR_FORWARD)  || (m.dir == DIR_RIGHT);
        m.bits[1] = (m.dir == DIR_BACKWARD) || (m.dir == DIR_LEFT);
        m.bits[2] = (m.dir == DIR_FORWARD)  || (m.dir == DIR_LEFT);
        m.bits[3] = (m.dir == DIR_BACKWARD) || (m.dir == DIR_RIGHT);
        m.right = r[7:0];
        m.left = l[7:0];
        return m;
    endfunction

    // start stays high across back-to-back items; only lowered when a gap follows
    task automatic send_sample(logic [9:0] x, logic [9:0] y, logic v);
        int gap;
        if (burst_mode)
            gap = 0;
        else
            gap = $urandom_range(0, 19);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        joystick_x <= x;
        joystick_y <= y;
        link_valid <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_sample(predict_mix(x, y, v));
        if ($urandom_range(0, 49) == 0)
            burst_mode = ~burst_mode;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_cfg(logic [0:0] idx, logic [9:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        if (idx == REG_UPPER)
            upper_thr = data;
        else
            lower_thr = data[8:0];
    endtask

    task automatic set_thresholds(logic [9:0] up, logic [9:0] low);
        wait_drained();
        write_cfg(REG_UPPER, up);
        write_cfg(REG_LOWER, low);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [9:0] pick_axis();
        int val;
        int t;
        case ($urandom_range(0, 3))
            0: val = $urandom_range(0, 1023);
            1:
            begin
                t = $urandom_range(0, 1) ? int'(upper_thr) : int'(lower_thr);
                val = t + $urandom_range(0, 6) - 3;
            end
            2:
            begin
                case ($urandom_range(0, 6))
                    0: val = 0;
                    1: val = 1;
                    2: val = 1022;
                    3: val = 1023;
                    4: val = 509;
                    5: val = 510;
                    default: val = 511;
                endcase
            end
            default: val = $urandom_range(490, 530);
        endcase
        if (val < 0)
            val = 0;
        if (val > 1023)
            val = 1023;
        return val[9:0];
    endfunction

    always @(posedge clk)
    begin
        mix_result_t got;
        if (rst_n && done)
        begin
            got.x = '0;
            got.y = '0;
            got.v = 1'b0;
            got.dir = dir_t'(direction);
            got.bits = bridge_bits;
            got.right = right_duty;
            got.left = left_duty;
            sb.check_result(got);
        end
    end

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int dir_x[$];
        int dir_y[$];
        int dir_v[$];
        int phase_up[$];
        int phase_low[$];
        int drain_at;
        logic [9:0] up;
        logic [9:0] low;

        dir_x = '{0, 1023, 0, 1023, 510, 510, 510, 1023, 0, 551, 550, 469, 470,
                  510, 510, 510, 510, 1023, 0, 700, 300, 1023, 0};
        dir_y = '{0, 1023, 1023, 0, 510, 1023, 0, 510, 510, 510, 510, 510, 510,
                  551, 550, 469, 470, 1023, 0, 800, 200, 1023, 0};
        dir_v = '{1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1,
                  1, 1, 1, 1, 0, 0, 1, 1, 1, 1};
        phase_up = '{510, 1023, 400, 0, 600, -1, -1, 550};
        phase_low = '{510, 0, 1023, 511, 300, -1, -1, 470};
        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        joystick_x = '0;
        joystick_y = '0;
        link_valid = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        upper_thr = UPPER_RESET;
        lower_thr = LOWER_RESET;
        burst_mode = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < dir_x.size(); i++)
            send_sample(10'(dir_x[i]), 10'(dir_y[i]), 1'(dir_v[i]));

        for (int p = 0; p < phase_up.size(); p++)
        begin
            if (phase_up[p] < 0)
            begin
                up = 10'($urandom_range(510, 1023));
                low = {1'($urandom_range(0, 1)), 9'($urandom_range(0, 510))};
            end
            else
            begin
                up = 10'(phase_up[p]);
                low = 10'(phase_low[p]);
            end
            set_thresholds(up, low);
            drain_at = $urandom_range(10, 130);
            for (int i = 0; i < 141; i++)
            begin
                if (i == drain_at)
                    wait_drained();
                send_sample(pick_axis(), pick_axis(), $urandom_range(0, 9) != 0);
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/jddm_pkg.sv
hw/rtl/jddm_axis_scale.sv
hw/rtl/jddm_mix.sv
hw/rtl/joystick_differential_drive_mixer.sv
tb/joystick_differential_drive_mixer_tb.sv
